// ===== design/rce_pkg.sv =====
// Shared types and constants for the Roberts cross edge magnitude core.
// No dependencies; used by every module of the block.
`default_nettype none

package rce_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT      = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ROOT_STEPS      = 9;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] gray_pixel;
        logic       frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]  edge_value;
        logic [10:0] out_column;
        logic [10:0] out_row;
        logic        last_of_run;
    } edge_out_t;

    // which results an item causes
    typedef struct packed {
        logic mag;
        logic above_pass;
        logic pixel_pass;
    } rce_flags_t;

    typedef struct packed {
        rce_flags_t  flags;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [7:0]  above;
        logic [7:0]  pixel;
        logic [10:0] col;
        logic [10:0] row;
    } rce_job_t;

endpackage

`default_nettype wire

// ===== design/rce_front.sv =====
// Front end: raster position tracking, line store and item classification.
// Depends on rce_pkg.
`default_nettype none

module rce_front
    import rce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [11:0] image_width,
    input  wire logic [11:0] image_height,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire pix_in_t     s_data,
    output logic             job_push,
    output rce_job_t         job_data,
    input  wire logic        job_full
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 12) ? WW : 12;

    logic [CW-1:0]   col_reg, col_next;
    logic [10:0]     row_reg, row_next;
    logic [7:0]      left_reg;
    logic [7:0]      diag_reg;
    logic            st_valid_reg, st_valid_next;
    logic [7:0]      st_pixel_reg;
    logic [7:0]      st_left_reg;
    logic [10:0]     st_col_reg;
    logic [10:0]     st_row_reg;
    rce_flags_t      st_flags_reg;
    logic [7:0]      line_rd_reg;
    logic [7:0]      line_mem [MAX_WIDTH];

    logic [CMPW-1:0] w_raw, w_eff, col_ext, c_cur, c_inc, c_nx;
    logic [11:0]     h_eff, r_cur, r_nx;
    rce_flags_t      flags;
    logic            accept, st_any, st_done;

    always_comb begin
        w_raw = CMPW'(image_width);
        if (w_raw < CMPW'(2)) begin
            w_eff = CMPW'(2);
        end else if (w_raw > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (image_height < 12'd2) begin
            h_eff = 12'd2;
        end else if (image_height > 12'(MAX_HEIGHT)) begin
            h_eff = 12'(MAX_HEIGHT);
        end else begin
            h_eff = image_height;
        end

        col_ext = CMPW'(col_reg);
        if (s_data.frame_start) begin
            c_cur = '0;
            r_cur = '0;
        end else if (col_ext >= w_eff) begin
            c_cur = '0;
            r_cur = 12'(row_reg) + 12'd1;
        end else begin
            c_cur = col_ext;
            r_cur = 12'(row_reg);
        end
        if (r_cur >= h_eff) begin
            r_cur = '0;
        end

        c_inc = c_cur + CMPW'(1);
        if (c_inc >= w_eff) begin
            c_nx = '0;
            r_nx = r_cur + 12'd1;
            if (r_nx >= h_eff) begin
                r_nx = '0;
            end
        end else begin
            c_nx = c_inc;
            r_nx = r_cur;
        end

        flags.mag        = (r_cur != '0) && (c_cur != '0);
        flags.above_pass = (r_cur != '0) && (c_cur == w_eff - CMPW'(1));
        flags.pixel_pass = (r_cur == h_eff - 12'd1);

        col_next = c_nx[CW-1:0];
        row_next = r_nx[10:0];
    end

    assign st_any   = st_flags_reg.mag | st_flags_reg.above_pass | st_flags_reg.pixel_pass;
    assign st_done  = st_valid_reg && (!st_any || !job_full);
    assign s_ready  = !st_valid_reg || st_done;
    assign accept   = s_valid && s_ready;
    assign job_push = st_valid_reg && st_any && !job_full;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept) begin
            st_valid_next = 1'b1;
        end else if (st_done) begin
            st_valid_next = 1'b0;
        end
    end

    always_comb begin
        job_data.flags = st_flags_reg;
        job_data.d1    = (diag_reg > st_pixel_reg) ? diag_reg - st_pixel_reg
                                                   : st_pixel_reg - diag_reg;
        job_data.d2    = (line_rd_reg > st_left_reg) ? line_rd_reg - st_left_reg
                                                     : st_left_reg - line_rd_reg;
        job_data.above = line_rd_reg;
        job_data.pixel = st_pixel_reg;
        job_data.col   = st_col_reg;
        job_data.row   = st_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            diag_reg     <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                left_reg <= s_data.gray_pixel;
            end
            if (st_done) begin
                diag_reg <= line_rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pixel_reg <= s_data.gray_pixel;
            st_left_reg  <= left_reg;
            st_col_reg   <= c_cur[10:0];
            st_row_reg   <= r_cur[10:0];
            st_flags_reg <= flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rd_reg            <= line_mem[c_cur[CW-1:0]];
            line_mem[c_cur[CW-1:0]] <= s_data.gray_pixel;
        end
    end

endmodule

`default_nettype wire

// ===== design/rce_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on rce_pkg.
`default_nettype none

module rce_queue
    import rce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire rce_job_t push_data,
    output logic          full,
    input  wire logic     pop,
    output rce_job_t      head,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    rce_job_t       slot_reg [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [NW-1:0]  count_reg, count_next;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== design/rce_back.sv =====
// Back end: sum of squares, iterative square root and result sequencing.
// Depends on rce_pkg.
`default_nettype none

module rce_back
    import rce_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rce_job_t job_head,
    input  wire logic     job_empty,
    output logic          job_pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output edge_out_t     m_data
);

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_SQUARE = 4'b0010,
        B_ROOT   = 4'b0100,
        B_OUT    = 4'b1000
    } back_state_t;

    localparam int SW = 2 * ROOT_STEPS;
    localparam int KW = $clog2(ROOT_STEPS + 1);

    back_state_t         state_reg, state_next;
    rce_job_t            job_reg;
    rce_flags_t          pend_reg, pend_next;
    logic [SW-1:0]       num_reg;
    logic [9:0]          rem_reg;
    logic [ROOT_STEPS-1:0] root_reg;
    logic [KW-1:0]       cnt_reg;
    logic                m_valid_reg, m_valid_next;
    edge_out_t           m_data_reg;

    logic [11:0]         rem_sh, trial;
    logic                take_bit;
    logic [7:0]          mag_sat;
    logic                load;
    edge_out_t           res;

    assign rem_sh   = {rem_reg, num_reg[SW-1 -: 2]};
    assign trial    = 12'({root_reg, 2'b01});
    assign take_bit = (rem_sh >= trial);
    assign mag_sat  = (root_reg > ROOT_STEPS'(255)) ? 8'd255 : root_reg[7:0];
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign load     = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        pend_next = pend_reg;
        res       = '0;
        priority if (pend_reg.mag) begin
            res.edge_value = mag_sat;
            res.out_column = job_reg.col - 11'd1;
            res.out_row    = job_reg.row - 11'd1;
            pend_next.mag  = 1'b0;
        end else if (pend_reg.above_pass) begin
            res.edge_value       = job_reg.above;
            res.out_column       = job_reg.col;
            res.out_row          = job_reg.row - 11'd1;
            pend_next.above_pass = 1'b0;
        end else begin
            res.edge_value       = job_reg.pixel;
            res.out_column       = job_reg.col;
            res.out_row          = job_reg.row;
            pend_next.pixel_pass = 1'b0;
        end
        res.last_of_run = (pend_next == '0);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            B_IDLE: begin
                if (!job_empty) begin
                    state_next = job_head.flags.mag ? B_SQUARE : B_OUT;
                end
            end
            B_SQUARE: state_next = B_ROOT;
            B_ROOT: begin
                if (cnt_reg == KW'(ROOT_STEPS - 1)) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    if (res.last_of_run) begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (job_pop) begin
                pend_reg <= job_head.flags;
            end else if (load) begin
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job_head;
        end
        if (state_reg == B_SQUARE) begin
            num_reg  <= SW'(16'(job_reg.d1) * 16'(job_reg.d1))
                      + SW'(16'(job_reg.d2) * 16'(job_reg.d2));
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        if (state_reg == B_ROOT) begin
            num_reg  <= {num_reg[SW-3:0], 2'b00};
            rem_reg  <= take_bit ? 10'(rem_sh - trial) : rem_sh[9:0];
            root_reg <= {root_reg[ROOT_STEPS-2:0], take_bit};
            cnt_reg  <= cnt_reg + KW'(1);
        end
        if (load) begin
            m_data_reg <= res;
        end
    end

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> (state_reg == B_IDLE))
        else $error("job taken outside idle");

    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROOT) |-> (cnt_reg < KW'(ROOT_STEPS)))
        else $error("square root ran past its last step");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_OUT && state_next == B_IDLE) |=> m_valid_reg && m_data_reg.last_of_run)
        else $error("final result of an item not flagged last");

endmodule

`default_nettype wire

// ===== design/roberts_cross_edge_magnitude_core.sv =====
// Top level of the Roberts cross edge magnitude core: config registers and wiring.
// Depends on rce_pkg, rce_front, rce_queue, rce_back.
//
//   channel   dir  handshake          payload
//   s_        in   s_valid/s_ready    pix_in_t   (gray_pixel, frame_start)
//   m_        out  m_valid/m_ready    edge_out_t (edge value, column, row, last)
//   apb       in   psel/penable       image_width @0x0, image_height @0x4
//
// Front takes one pixel per cycle while the job queue has room.
// Back: a magnitude item goes through the square state and 9 root steps, then loads each
// result into the output register; a pass-through item goes straight to its results. Row 0 items cause no job.
// The square root sequencer in the back end sets the sustained rate.
// Reset is synchronous; line store contents are not cleared.
// Either side may stall; the queue and output register decouple them.
`default_nettype none

module roberts_cross_edge_magnitude_core
    import rce_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire pix_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output edge_out_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        job_push, job_full, job_pop, job_empty;
    rce_job_t    push_data, head;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = {20'd0, width_reg};
            REG_IDX_HEIGHT: prdata = {20'd0, height_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_reg  <= pwdata[11:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    rce_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .job_push     (job_push),
        .job_data     (push_data),
        .job_full     (job_full)
    );

    rce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_data),
        .full      (job_full),
        .pop       (job_pop),
        .head      (head),
        .empty     (job_empty)
    );

    rce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_head  (head),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== verif/tb_roberts_cross_edge_magnitude_core.sv =====
// Self-checking testbench for roberts_cross_edge_magnitude_core: raster frames of gray
// pixels at many frame sizes, every result checked against an in-bench edge predictor.
// Depends on rce_pkg and the core RTL only.

module tb_roberts_cross_edge_magnitude_core;
    import rce_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_REPORTS   = 10;

    // Tracks position, line store and sizes; queues the edge results each pixel causes.
    class edge_checker;
        logic [7:0]  line_mem [0:2047];
        logic [7:0]  left_px;
        logic [7:0]  diag_px;
        int unsigned col_pos;
        int unsigned row_pos;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        edge_out_t   pending_edges[$];
        int          errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = 8'd0;
            left_px    = 8'd0;
            diag_px    = 8'd0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, logic [11:0] value);
            if (idx == REG_IDX_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int unsigned line_span();
            return (width_reg < 2) ? 2 : (width_reg > 2048) ? 2048 : width_reg;
        endfunction

        function int unsigned frame_rows();
            return (height_reg < 2) ? 2 : (height_reg > 2048) ? 2048 : height_reg;
        endfunction

        function int unsigned floor_root(int unsigned n);
            int unsigned r;
            r = 0;
            for (int b = 15; b >= 0; b--) begin
                if ((r | (1 << b)) * (r | (1 << b)) <= n) r = r | (1 << b);
            end
            return r;
        endfunction

        function edge_out_t make_edge(int unsigned value, int unsigned col, int unsigned row);
            edge_out_t e;
            e.edge_value  = value[7:0];
            e.out_column  = col[10:0];
            e.out_row     = row[10:0];
            e.last_of_run = 1'b0;
            return e;
        endfunction

        function void take_pixel(pix_in_t px);
            int unsigned w, h, c, r, p, above, d1, d2, mag;
            edge_out_t   batch[$];
            w = line_span();
            h = frame_rows();
            c = col_pos;
            r = row_pos;
            p = px.gray_pixel;
            if (px.frame_start) begin
                c = 0;
                r = 0;
            end else if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;
            above = line_mem[c];
            if (r >= 1 && c >= 1) begin
                d1  = (diag_px > p) ? diag_px - p : p - diag_px;
                d2  = (above > left_px) ? above - left_px : left_px - above;
                mag = floor_root(d1 * d1 + d2 * d2);
                if (mag > 255) mag = 255;
                batch.push_back(make_edge(mag, c - 1, r - 1));
            end
            if (r >= 1 && c == w - 1) batch.push_back(make_edge(above, c, r - 1));
            if (r == h - 1) batch.push_back(make_edge(p, c, r));
            if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[i]) pending_edges.push_back(batch[i]);
            diag_px     = above[7:0];
            left_px     = p[7:0];
            line_mem[c] = p[7:0];
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void check_edge(edge_out_t got);
            edge_out_t want;
            if (pending_edges.size() == 0) begin
                flag($sformatf("unexpected result: val=%0d col=%0d row=%0d last=%0b",
                    got.edge_value, got.out_column, got.out_row, got.last_of_run));
                return;
            end
            want = pending_edges.pop_front();
            if (got.edge_value !== want.edge_value || got.out_column !== want.out_column ||
                got.out_row !== want.out_row || got.last_of_run !== want.last_of_run) begin
                flag($sformatf({"result mismatch: expected val=%0d col=%0d row=%0d last=%0b,",
                    " got val=%0d col=%0d row=%0d last=%0b"},
                    want.edge_value, want.out_column, want.out_row, want.last_of_run,
                    got.edge_value, got.out_column, got.out_row, got.last_of_run));
            end
        endfunction

        function int pending();
            return pending_edges.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pix_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    edge_out_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    edge_checker chk = new();
    bit          calm = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned cur_span = 0;

    logic [7:0] intro_px [0:22] = '{
        8'd0, 8'd255, 8'd17, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd9,
        8'd200, 8'd10, 8'd255, 8'd33, 8'd0,
        8'd7, 8'd90, 8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd254, 8'd128
    };

    roberts_cross_edge_magnitude_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) chk.take_pixel(s_data);
            if (m_valid && m_ready) chk.check_edge(m_data);
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready  <= 1'b0;
            hold_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    function automatic logic [7:0] pick_gray();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [7:0] gray, input logic fs);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {gray, fs};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // two back-to-back register writes: width, then height
    task automatic set_frame_size(input logic [11:0] w, input logic [11:0] h);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IDX_WIDTH, 2'b00};
        pwdata  <= {20'd0, w};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        chk.set_reg(REG_IDX_WIDTH, w);
        penable <= 1'b0;
        paddr   <= {REG_IDX_HEIGHT, 2'b00};
        pwdata  <= {20'd0, h};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        chk.set_reg(REG_IDX_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (chk.pending() != 0) @(posedge aclk);
    endtask

    // keep_position continues the current frame unless the rows got wider
    task automatic run_frames(input logic [11:0] w, input logic [11:0] h,
                              input int count, input bit keep_position);
        int unsigned span;
        bit          fresh;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        calm <= ($urandom_range(0, 3) == 0);
        set_frame_size(w, h);
        span     = chk.line_span();
        fresh    = !keep_position || span > cur_span;
        cur_span = span;
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_gray(), (i == 0 && fresh) || $urandom_range(0, 99) < 3);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x3 frames: saturated magnitude, three results on the corner pixel,
        // wrap into the next frame, then a frame start in mid-frame
        set_frame_size(12'd3, 12'd3);
        cur_span = 3;
        for (int i = 0; i < 23; i++) begin
            send_pixel(intro_px[i], i == 0 || i == 14);
        end
        s_valid <= 1'b0;

        run_frames(12'd1, 12'd0, 8, 1'b0);
        for (int p = 0; p < 3; p++) begin
            run_frames(($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 1))
                                                   : 12'($urandom_range(2, 9)),
                       ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 1))
                                                   : 12'($urandom_range(2, 6)),
                       $urandom_range(8, 12), 1'($urandom_range(0, 1)));
        end

        // shrink mid-frame: column past the new width, then row past the new height
        run_frames(12'd7, 12'd5, 12, 1'b0);
        run_frames(12'd4, 12'd5, 9, 1'b1);
        run_frames(12'd4, 12'd3, 10, 1'b1);

        // sizes above the limits, clamped
        run_frames(12'd4095, 12'd2, 6, 1'b0);
        run_frames(12'd2, 12'd4095, 6, 1'b0);

        drain();
        repeat (40) @(posedge aclk);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
